// File: design/pte_pkg.sv
// Shared types, codes and constants of the polynomial trajectory evaluator.
package pte_pkg;

  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int VAL_W     = 48;
  localparam int TIME_W    = 32;
  localparam int TERM_W    = 4;
  localparam int AXIS_W    = 3;
  localparam int IDX_W     = 3;
  localparam int JC_W      = 53;

  localparam logic [CMD_W-1:0] CMD_LOAD_COEF  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_END   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_START_TIME = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END_TIME   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_TERMS  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_AXES   = 2'd3;

  localparam logic [VAL_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] NEG_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         term_index;
    logic [AXIS_W-1:0]        axis_index;
    logic signed [VAL_W-1:0]  load_value;
    logic signed [TIME_W-1:0] query_time;
  } pte_req_t;

  typedef struct packed {
    logic [AXIS_W-1:0]       axis;
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] velocity;
    logic                    clamped;
    logic                    overflow;
    logic                    last;
  } pte_res_t;

  // Operation for the shared multiply-accumulate unit.
  typedef struct packed {
    logic signed [VAL_W-1:0]  a;
    logic signed [TIME_W-1:0] m;
    logic signed [JC_W-1:0]   b;
    logic                     rnd;
  } pte_mac_op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    ovf;
    logic signed [JC_W-1:0]  raw;
  } pte_mac_res_t;

endpackage

// File: design/pte_stream_if.sv
// Valid/ready stream channel carrying one payload per request.
interface pte_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/pte_mac.sv
// Shared multi-cycle multiply, round, add and saturate unit.
module pte_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pte_pkg::pte_mac_op_t  op,
  output logic                  done,
  output pte_pkg::pte_mac_res_t res
);
  import pte_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LO   = 3'd1;
  localparam logic [2:0] PH_HI   = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_ADD  = 3'd4;

  localparam logic [79:0] ROUND_HALF = 80'h8000;

  logic [2:0]          ph;
  pte_mac_op_t         op_q;
  logic signed [56:0]  mreg;
  logic signed [79:0]  prod;
  logic signed [79:0]  prod_hi;
  logic signed [79:0]  shifted;
  logic signed [65:0]  scaled;
  logic signed [65:0]  sum;
  logic                sat_ovf;
  logic [VAL_W-1:0]    sat_val;

  always_comb begin
    prod_hi = {mreg[55:0], 24'd0};
    shifted = prod >>> 16;
    scaled  = op_q.rnd ? shifted[65:0] : prod[65:0];
    sum     = scaled + {{13{op_q.b[JC_W-1]}}, op_q.b};
    // The sum fits 48 bits only when all bits above bit 46 agree.
    sat_ovf = !((&sum[65:47]) || !(|sum[65:47]));
    sat_val = sat_ovf ? (sum[65] ? NEG_MIN : POS_MAX) : sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
    end else begin
      done <= (ph == PH_ADD);
      case (ph)
        PH_IDLE: if (start) ph <= PH_LO;
        PH_LO:   ph <= PH_HI;
        PH_HI:   ph <= PH_SUM;
        PH_SUM:  ph <= PH_ADD;
        PH_ADD:  ph <= PH_IDLE;
        default: ph <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == PH_IDLE && start) op_q <= op;
    case (ph)
      PH_LO: mreg <= $signed({1'b0, op_q.a[23:0]}) * $signed(op_q.m);
      PH_HI: begin
        prod <= {{23{mreg[56]}}, mreg};
        mreg <= $signed(op_q.a[47:24]) * $signed(op_q.m);
      end
      PH_SUM: prod <= prod + prod_hi + (op_q.rnd ? ROUND_HALF : 80'd0);
      PH_ADD: begin
        res.value <= sat_val;
        res.ovf   <= sat_ovf;
        res.raw   <= sum[JC_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

// File: design/pte_store.sv
// Coefficient memory and per-axis start and end position stores.
module pte_store #(
  parameter  int MAX_TERMS = 8,
  parameter  int MAX_AXES  = 6,
  localparam int Depth     = MAX_TERMS * MAX_AXES,
  localparam int CW        = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  pte_pkg::pte_req_t                wr,
  input  logic [CW-1:0]                    raddr,
  input  logic [pte_pkg::AXIS_W-1:0]       ep_axis,
  output logic signed [pte_pkg::VAL_W-1:0] coef_q,
  output logic signed [pte_pkg::VAL_W-1:0] start_q,
  output logic signed [pte_pkg::VAL_W-1:0] end_q
);
  import pte_pkg::*;

  localparam int AXW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

  logic [VAL_W-1:0] coef_mem  [Depth];
  logic [VAL_W-1:0] start_mem [MAX_AXES];
  logic [VAL_W-1:0] end_mem   [MAX_AXES];

  logic          axis_ok;
  logic          term_ok;
  logic [CW-1:0] waddr;

  always_comb begin
    axis_ok = int'(wr.axis_index) < MAX_AXES;
    term_ok = int'(wr.term_index) < MAX_TERMS;
    waddr   = CW'(int'(wr.axis_index) * MAX_TERMS + int'(wr.term_index));
  end

  always_ff @(posedge clk) begin
    if (wr_en && axis_ok) begin
      case (wr.cmd)
        CMD_LOAD_COEF:  if (term_ok) coef_mem[waddr] <= wr.load_value;
        CMD_LOAD_START: start_mem[AXW'(wr.axis_index)] <= wr.load_value;
        CMD_LOAD_END:   end_mem[AXW'(wr.axis_index)] <= wr.load_value;
        default: ;
      endcase
    end
    coef_q  <= coef_mem[raddr];
    start_q <= start_mem[AXW'(ep_axis)];
    end_q   <= end_mem[AXW'(ep_axis)];
  end

endmodule

// File: design/polynomial_trajectory_evaluator_unit.sv
// Top level of the polynomial trajectory evaluator: sequencer, registers and result stage.
// Requests either load a coefficient, a start position or an end position (producing nothing),
// or query the trajectory at a signed Q16.16 time. A query produces one result per axis in
// use, in axis order, with last set on the final one. All arithmetic runs through a single
// shared multiply-accumulate unit, with the coefficient memory read ahead of each step. The
// block takes no new request until the last result of a query has been handed to the result
// register, which lets one result wait for the consumer while the next axis is computed.
// Configuration registers may only be written while no query is in flight. Reading a store
// entry that was never loaded returns undefined data.
module polynomial_trajectory_evaluator_unit #(
  parameter int MAX_TERMS = 8,
  parameter int MAX_AXES  = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  pte_stream_if.sink                      req,
  pte_stream_if.source                    res,
  input  logic                            cfg_we,
  input  logic [pte_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [pte_pkg::CFG_W-1:0]       cfg_data
);
  import pte_pkg::*;

  localparam int Depth = MAX_TERMS * MAX_AXES;
  localparam int CW    = (Depth > 1) ? $clog2(Depth) : 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AXIS  = 4'd1;
  localparam logic [3:0] S_SEL   = 4'd2;
  localparam logic [3:0] S_PREAD = 4'd3;
  localparam logic [3:0] S_PUSE  = 4'd4;
  localparam logic [3:0] S_PWAIT = 4'd5;
  localparam logic [3:0] S_VREAD = 4'd6;
  localparam logic [3:0] S_VUSE  = 4'd7;
  localparam logic [3:0] S_VJC   = 4'd8;
  localparam logic [3:0] S_VMAC  = 4'd9;
  localparam logic [3:0] S_VWAIT = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] state;

  // Configuration registers.
  logic signed [TIME_W-1:0] start_time;
  logic signed [TIME_W-1:0] end_time;
  logic [TERM_W-1:0]        num_terms;
  logic [AXIS_W-1:0]        num_axes;

  // Per-query and per-axis working registers.
  logic signed [TIME_W-1:0] t;
  logic                     clamp_lo;
  logic                     clamp_hi;
  logic [AXIS_W-1:0]        axis_cnt;
  logic [CW-1:0]            coef_base;
  logic [TERM_W-1:0]        j;
  logic                     first;
  logic signed [VAL_W-1:0]  acc;
  logic signed [VAL_W-1:0]  vel;
  logic signed [JC_W-1:0]   jc;
  logic                     ovf;

  logic                     res_valid;
  pte_res_t                 res_data;

  logic [TERM_W-1:0]        n_eff;
  logic [AXIS_W-1:0]        na_eff;
  logic [CW-1:0]            raddr;
  logic                     store_we;
  logic signed [VAL_W-1:0]  coef_q;
  logic signed [VAL_W-1:0]  start_q;
  logic signed [VAL_W-1:0]  end_q;
  logic                     mac_start;
  pte_mac_op_t              mac_op;
  logic                     mac_done;
  pte_mac_res_t             mac_res;
  logic                     last_axis;

  assign req.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // Counts beyond what the storage holds are limited to the storage size.
  always_comb begin
    n_eff     = (int'(num_terms) > MAX_TERMS) ? TERM_W'(MAX_TERMS) : num_terms;
    na_eff    = (int'(num_axes) > MAX_AXES) ? AXIS_W'(MAX_AXES) : num_axes;
    raddr     = coef_base + CW'(j);
    store_we  = req.valid && req.ready && (req.data.cmd != CMD_QUERY);
    last_axis = (axis_cnt + 3'd1) == na_eff;
  end

  // Operand selection for the shared unit. Position steps multiply by the time with rounding
  // and add the next coefficient; velocity steps first form j times the coefficient exactly,
  // then run the same Horner step with that product as the addend.
  always_comb begin
    mac_start = 1'b0;
    mac_op    = '0;
    case (state)
      S_PUSE: begin
        mac_start  = !first;
        mac_op.a   = acc;
        mac_op.m   = t;
        mac_op.b   = {{(JC_W - VAL_W){coef_q[VAL_W-1]}}, coef_q};
        mac_op.rnd = 1'b1;
      end
      S_VUSE: begin
        mac_start  = 1'b1;
        mac_op.a   = coef_q;
        mac_op.m   = {{(TIME_W - TERM_W){1'b0}}, j};
        mac_op.rnd = 1'b0;
      end
      S_VMAC: begin
        mac_start  = 1'b1;
        mac_op.a   = vel;
        mac_op.m   = t;
        mac_op.b   = jc;
        mac_op.rnd = 1'b1;
      end
      default: ;
    endcase
  end

  pte_store #(
    .MAX_TERMS (MAX_TERMS),
    .MAX_AXES  (MAX_AXES)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr      (req.data),
    .raddr   (raddr),
    .ep_axis (axis_cnt),
    .coef_q  (coef_q),
    .start_q (start_q),
    .end_q   (end_q)
  );

  pte_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .op    (mac_op),
    .done  (mac_done),
    .res   (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start_time <= '0;
      end_time   <= '0;
      num_terms  <= TERM_W'(1);
      num_axes   <= AXIS_W'(1);
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_TIME: start_time <= cfg_data[TIME_W-1:0];
          REG_END_TIME:   end_time   <= cfg_data[TIME_W-1:0];
          REG_NUM_TERMS:  num_terms  <= cfg_data[TERM_W-1:0];
          REG_NUM_AXES:   num_axes   <= cfg_data[AXIS_W-1:0];
          default: ;
        endcase
      end

      // In the emit state a taken result is replaced by the next one below.
      if (res_valid && res.ready && state != S_EMIT) res_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          // A query with no axes in use yields nothing and is simply absorbed.
          if (req.valid && req.data.cmd == CMD_QUERY && na_eff != '0) begin
            t         <= req.data.query_time;
            clamp_lo  <= $signed(req.data.query_time) < $signed(start_time);
            clamp_hi  <= $signed(req.data.query_time) > $signed(end_time);
            axis_cnt  <= '0;
            coef_base <= '0;
            state     <= S_AXIS;
          end
        end
        // The endpoint stores are read during this cycle for the current axis.
        S_AXIS: state <= S_SEL;
        S_SEL: begin
          ovf <= 1'b0;
          vel <= '0;
          if (clamp_lo || clamp_hi) begin
            // The start-time test wins when the start lies after the end.
            acc   <= clamp_lo ? start_q : end_q;
            state <= S_EMIT;
          end else if (n_eff == '0) begin
            acc   <= '0;
            state <= S_EMIT;
          end else begin
            j     <= n_eff - TERM_W'(1);
            first <= 1'b1;
            state <= S_PREAD;
          end
        end
        S_PREAD: state <= S_PUSE;
        S_PUSE: begin
          if (first) begin
            acc   <= coef_q;
            first <= 1'b0;
            if (j == '0) begin
              // A single term has a zero derivative.
              vel   <= '0;
              state <= S_EMIT;
            end else begin
              j     <= j - TERM_W'(1);
              state <= S_PREAD;
            end
          end else begin
            state <= S_PWAIT;
          end
        end
        S_PWAIT: begin
          if (mac_done) begin
            acc <= mac_res.value;
            ovf <= ovf | mac_res.ovf;
            if (j == '0) begin
              j     <= n_eff - TERM_W'(1);
              first <= 1'b1;
              state <= S_VREAD;
            end else begin
              j     <= j - TERM_W'(1);
              state <= S_PREAD;
            end
          end
        end
        S_VREAD: state <= S_VUSE;
        S_VUSE:  state <= S_VJC;
        S_VJC: begin
          if (mac_done) begin
            if (first) begin
              // Leading velocity term: (n-1) times the top coefficient, saturated.
              vel   <= mac_res.value;
              ovf   <= ovf | mac_res.ovf;
              first <= 1'b0;
              if (j == TERM_W'(1)) begin
                state <= S_EMIT;
              end else begin
                j     <= j - TERM_W'(1);
                state <= S_VREAD;
              end
            end else begin
              jc    <= mac_res.raw;
              state <= S_VMAC;
            end
          end
        end
        S_VMAC: state <= S_VWAIT;
        S_VWAIT: begin
          if (mac_done) begin
            vel <= mac_res.value;
            ovf <= ovf | mac_res.ovf;
            if (j == TERM_W'(1)) begin
              state <= S_EMIT;
            end else begin
              j     <= j - TERM_W'(1);
              state <= S_VREAD;
            end
          end
        end
        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_valid         <= 1'b1;
            res_data.axis     <= axis_cnt;
            res_data.position <= acc;
            res_data.velocity <= vel;
            res_data.clamped  <= clamp_lo || clamp_hi;
            res_data.overflow <= ovf && !(clamp_lo || clamp_hi);
            res_data.last     <= last_axis;
            if (last_axis) begin
              state <= S_IDLE;
            end else begin
              axis_cnt  <= axis_cnt + 3'd1;
              coef_base <= coef_base + CW'(MAX_TERMS);
              state     <= S_AXIS;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The shared unit only finishes while the sequencer is waiting for it.
  a_mac_done_waiting: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == S_PWAIT || state == S_VJC || state == S_VWAIT))
    else $error("arithmetic unit finished outside a waiting state");

  // A finished axis reaches the result register as soon as it is free.
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!res_valid || res.ready)) |=> res_valid)
    else $error("result not presented after emit");

  // Clamped results carry zero velocity and never report overflow.
  a_clamp_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.clamped) |-> (!res_data.overflow && res_data.velocity == '0))
    else $error("clamped result with velocity or overflow");

  // An accepted query with axes in use starts the per-axis sequence.
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.cmd == CMD_QUERY && na_eff != '0) |=> state == S_AXIS)
    else $error("query request did not start evaluation");
`endif

endmodule
